// ----- design/cpc_pkg.sv -----
//------------------------------------------------------------------------------
// cpc_pkg
// Shared constants for the convex polygon line clipper.
//------------------------------------------------------------------------------
`default_nettype none
package cpc_pkg;
    localparam int MAX_VERTICES_DEF = 8;
    localparam int COORD_BITS_DEF   = 16;
    localparam int T_FRAC           = 16;
    localparam int T_BITS           = T_FRAC + 1;
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC;
    localparam int CNT_BITS         = 4;
    localparam logic [CNT_BITS-1:0] CNT_RESET = 4'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CLIP = 1'b1;
endpackage
`default_nettype wire

// ----- design/cpc_divider.sv -----
//------------------------------------------------------------------------------
// cpc_divider
// Restoring fraction divider: q = floor(a * 2^16 / b) for 0 < a < b.
//------------------------------------------------------------------------------
`default_nettype none
module cpc_divider #(
    parameter int W = 40
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [W-1:0]              a,
    input  wire logic [W-1:0]              b,
    output logic                           done,
    output logic [cpc_pkg::T_FRAC-1:0]     quot
);
    import cpc_pkg::*;

    logic [W:0]              rem_reg;
    logic [W-1:0]            div_reg;
    logic [T_FRAC-1:0]       q_reg;
    logic [4:0]              cnt_reg;
    logic                    busy_reg;
    logic [W:0]              shifted;
    logic [W:0]              diff;

    assign shifted = {rem_reg[W-1:0], 1'b0};
    assign diff    = shifted - {1'b0, div_reg};

    // one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= {1'b0, a};
                div_reg  <= b;
                q_reg    <= '0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (!diff[W])
                begin
                    rem_reg <= diff;
                    q_reg   <= {q_reg[T_FRAC-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    q_reg   <= {q_reg[T_FRAC-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(T_FRAC - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg;

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> busy_reg || done) else $error("divider lost");
endmodule
`default_nettype wire

// ----- design/convex_polygon_line_clipper_top.sv -----
//------------------------------------------------------------------------------
// convex_polygon_line_clipper_top
// Cyrus-Beck clipping of a segment against a convex vertex table.
//------------------------------------------------------------------------------
// Clip item: per edge a table read, the normal, four products, a decision, an optional
// division and an update; then four scaled end coordinates and the output. One shared
// multiplier and a 16-step bit-serial divider set the clip time. A degenerate segment
// goes straight to the output. One item at a time; s_tready low while busy.
// Reset clears control and vertex_count (3); the vertex table is not cleared.
`default_nettype none
module convex_polygon_line_clipper_top #(
    parameter int MAX_VERTICES = cpc_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpc_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [cpc_pkg::CNT_BITS-1:0] cfg_wdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // operation, vertex_index, start_x, start_y, end_x, end_y, zero pad
    input  wire logic [((4*COORD_BITS+4+7)/8)*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero pad
    output logic [((4*COORD_BITS+1+7)/8)*8-1:0] m_tdata
);
    import cpc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int IW = ((4*C+4+7)/8)*8;
    localparam int OW = ((4*C+1+7)/8)*8;
    localparam int IB = $clog2(MAX_VERTICES);
    localparam int DW = C + 1;          // difference width
    localparam int PW = 2*DW + 1;       // dot product width
    localparam int SW = T_BITS + DW + 1; // t*d width
    localparam int MW = (DW > T_BITS + 1) ? DW : T_BITS + 1; // multiplier operand

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_M1, S_M2, S_M3, S_M4, S_M5, S_DEC, S_DIV, S_UPD,
        S_SC, S_OUT
    } state_t;

    state_t                  state_reg;
    logic [CNT_BITS-1:0]     count_reg;
    logic signed [C-1:0]     vx_mem [MAX_VERTICES];
    logic signed [C-1:0]     vy_mem [MAX_VERTICES];
    logic signed [C-1:0]     x0_reg, y0_reg;
    logic signed [DW-1:0]    dx_reg, dy_reg;
    logic [IB-1:0]           i_reg;
    logic [IB:0]             n_reg;
    logic signed [C-1:0]     vix_reg, viy_reg, vjx_reg, vjy_reg;
    logic signed [DW-1:0]    nx_reg, ny_reg;
    logic signed [PW-1:0]    num_reg, den_reg;
    logic [T_BITS-1:0]       te_reg, tl_reg;
    logic                    enter_reg;
    logic [1:0]              sc_reg;
    logic signed [C-1:0]     res_reg [4];
    logic                    vis_reg;

    // shared multiplier
    logic signed [MW-1:0]    ma, mb;
    logic signed [2*MW-1:0]  prod;
    logic signed [SW-1:0]    sprod;
    logic signed [T_BITS:0]  st;

    logic [IW-1:0] din;
    logic          div_start, div_done;
    logic [PW-1:0] div_a, div_b;
    logic [T_FRAC-1:0] div_q;
    logic signed [PW-1:0] a_val, b_val;
    logic [IB:0]   n_eff;
    logic [IB-1:0] j_idx;
    logic [T_BITS-1:0] t_cur;

    assign din = s_tdata;
    assign s_tready = (state_reg == S_IDLE);
    assign prod = ma * mb;
    assign st = $signed({1'b0, (sc_reg < 2'd2) ? te_reg : tl_reg});
    assign sprod = SW'(prod);

    // effective vertex count, clamped
    always_comb
    begin
        if (count_reg < 4'd3)
            n_eff = (IB+1)'(3);
        else if (32'(count_reg) > MAX_VERTICES)
            n_eff = (IB+1)'(MAX_VERTICES);
        else
            n_eff = (IB+1)'(count_reg);
        j_idx = ((IB+1)'(i_reg) + (IB+1)'(1) == n_reg) ? '0 : i_reg + IB'(1);
    end

    // operand select for the multiplier
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_M2:    begin ma = MW'(DW'(x0_reg) - DW'(vix_reg)); mb = MW'(nx_reg); end
            S_M3:    begin ma = MW'(DW'(y0_reg) - DW'(viy_reg)); mb = MW'(ny_reg); end
            S_M4:    begin ma = MW'(dx_reg); mb = MW'(nx_reg); end
            S_M5:    begin ma = MW'(dy_reg); mb = MW'(ny_reg); end
            S_SC:    begin ma = MW'(st); mb = MW'(sc_reg[0] ? dy_reg : dx_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // division operands follow the sign of the denominator
    assign a_val = (den_reg > 0) ? -num_reg : num_reg;
    assign b_val = (den_reg > 0) ? den_reg : -den_reg;
    assign div_a = a_val;
    assign div_b = b_val;
    assign div_start = (state_reg == S_DEC) && (den_reg != '0) && (a_val > 0)
                       && (a_val < b_val);
    assign t_cur = div_done ? {1'b0, div_q} : '0;

    cpc_divider #(.W(PW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a), .b(div_b),
        .done(div_done), .quot(div_q)
    );

    // vertex table
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready && din[0] == OP_LOAD && 32'(din[3:1]) < MAX_VERTICES)
        begin
            vx_mem[IB'(din[3:1])] <= din[4 +: C];
            vy_mem[IB'(din[3:1])] <= din[4+C +: C];
        end
        vix_reg <= vx_mem[i_reg];
        viy_reg <= vy_mem[i_reg];
        vjx_reg <= vx_mem[j_idx];
        vjy_reg <= vy_mem[j_idx];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_RESET;
            m_tvalid  <= 1'b0;
            m_tdata   <= '0;
            te_reg    <= '0;
            tl_reg    <= T_ONE;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_wdata;
            // result handshake
            if (state_reg == S_OUT && (!m_tvalid || m_tready))
                m_tvalid <= 1'b1;
            else if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && din[0] == OP_CLIP)
                    begin
                        x0_reg <= din[4 +: C];
                        y0_reg <= din[4+C +: C];
                        dx_reg <= DW'($signed(din[4+2*C +: C])) - DW'($signed(din[4 +: C]));
                        dy_reg <= DW'($signed(din[4+3*C +: C])) - DW'($signed(din[4+C +: C]));
                        te_reg <= '0;
                        tl_reg <= T_ONE;
                        i_reg  <= '0;
                        n_reg  <= n_eff;
                        vis_reg <= 1'b0;
                        if (din[4+2*C +: 2*C] == din[4 +: 2*C])
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    // wait for the registered table read
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    nx_reg <= DW'(viy_reg) - DW'(vjy_reg);
                    ny_reg <= DW'(vjx_reg) - DW'(vix_reg);
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    num_reg <= PW'(prod);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    num_reg <= num_reg + PW'(prod);
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    den_reg <= PW'(prod);
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    den_reg <= den_reg + PW'(prod);
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    enter_reg <= 1'b0;
                    if (den_reg == '0)
                    begin
                        state_reg <= num_reg < 0 ? S_OUT : S_UPD;
                        te_reg <= te_reg;
                    end
                    else if (den_reg > 0)
                    begin
                        // entering edge
                        enter_reg <= 1'b1;
                        if (-num_reg > den_reg)
                            state_reg <= S_OUT;
                        else if (div_start)
                            state_reg <= S_DIV;
                        else
                        begin
                            if (-num_reg == den_reg)
                            begin
                                if (T_ONE > tl_reg) state_reg <= S_OUT;
                                else begin te_reg <= T_ONE; state_reg <= S_UPD; end
                            end
                            else
                                state_reg <= S_UPD;
                        end
                    end
                    else
                    begin
                        // leaving edge
                        if (num_reg < 0)
                            state_reg <= S_OUT;
                        else if (div_start)
                            state_reg <= S_DIV;
                        else if (num_reg == 0)
                        begin
                            if (te_reg != '0) state_reg <= S_OUT;
                            else begin tl_reg <= '0; state_reg <= S_UPD; end
                        end
                        else
                            state_reg <= S_UPD;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (enter_reg)
                        begin
                            if (t_cur > tl_reg) state_reg <= S_OUT;
                            else
                            begin
                                if (t_cur > te_reg) te_reg <= t_cur;
                                state_reg <= S_UPD;
                            end
                        end
                        else
                        begin
                            if (t_cur < te_reg) state_reg <= S_OUT;
                            else
                            begin
                                if (t_cur < tl_reg) tl_reg <= t_cur;
                                state_reg <= S_UPD;
                            end
                        end
                    end
                end
                S_UPD:
                begin
                    // next edge or scale
                    if ((IB+1)'(i_reg) + (IB+1)'(1) == n_reg)
                    begin
                        if (te_reg > tl_reg) state_reg <= S_OUT;
                        else
                        begin
                            sc_reg <= '0;
                            state_reg <= S_SC;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + IB'(1);
                        state_reg <= S_EDGE;
                    end
                end
                S_SC:
                begin
                    // p0 + round(t*d), ties up
                    res_reg[sc_reg] <= (sc_reg[0] ? y0_reg : x0_reg)
                        + C'((sprod + SW'(32768)) >>> T_FRAC);
                    sc_reg <= sc_reg + 2'd1;
                    if (sc_reg == 2'd3)
                    begin
                        vis_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tdata  <= vis_reg ? OW'({res_reg[3], res_reg[2], res_reg[1],
                                                  res_reg[0], 1'b1}) : '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_tready) else $error("ready while busy");
    a_t_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SC |-> te_reg <= tl_reg) else $error("bad t interval");
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        tl_reg <= T_ONE) else $error("tL out of range");
endmodule
`default_nettype wire
